@@ design/otil_pkg.sv @@
// ----------------------------------------------------------------------------
// otil_pkg: shared types and codes for the object table
// Request kinds, result status codes, entry layout and controller states.
// ----------------------------------------------------------------------------
`default_nettype none

package otil_pkg;

  // Request kinds
  localparam logic [1:0] KIND_ADD   = 2'd0;
  localparam logic [1:0] KIND_FIND  = 2'd1;
  localparam logic [1:0] KIND_GET   = 2'd2;
  localparam logic [1:0] KIND_CLEAR = 2'd3;

  // Result status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_DUPLICATE = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_RANGE     = 3'd4;

  // Field widths fixed by the interface
  localparam int ClassW   = 16;
  localparam int CodeW    = 48;
  localparam int VersionW = 8;
  localparam int IndexW   = 7;
  localparam int TotalW   = 8;

  // One stored entry
  typedef struct packed {
    logic [ClassW-1:0]   cls;
    logic [CodeW-1:0]    code;
    logic [VersionW-1:0] version;
  } entry_t;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_GET,
    S_REPLY
  } state_t;

endpackage

`default_nettype wire

@@ design/object_table_insert_lookup_core.sv @@
// ----------------------------------------------------------------------------
// object_table_insert_lookup_core: object table with append and linear search
// Entries live in one synchronous RAM; add and find walk it one entry a cycle.
// ----------------------------------------------------------------------------
// Sequence: an add or find reads one RAM entry per cycle while entries remain,
//   compares the read data in the cycle after each read, and registers the
//   result before out_valid; a full-table add, a clear and an out-of-range get
//   go straight to the reply state, while an in-range get reads the RAM first.
// Throughput: one request at a time; the next request is taken once the
//   result sits in the output register. The RAM read port sets the scan rate.
// Reset: clears the entry count and the handshake state; the RAM is not
//   cleared, entries at or above the count are never read.
`default_nettype none

module object_table_insert_lookup_core #(
  parameter int ENTRIES = 64
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // request channel
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [1:0]                      kind,
  input  wire logic [otil_pkg::ClassW-1:0]     obj_class,
  input  wire logic [otil_pkg::CodeW-1:0]      obis,
  input  wire logic [otil_pkg::VersionW-1:0]   version,
  input  wire logic [otil_pkg::IndexW-1:0]     index,
  // result channel
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [2:0]                           status,
  output logic [otil_pkg::IndexW-1:0]          entry_index,
  output logic [otil_pkg::ClassW-1:0]          entry_class,
  output logic [otil_pkg::CodeW-1:0]           entry_code,
  output logic [otil_pkg::VersionW-1:0]        entry_version,
  output logic [otil_pkg::TotalW-1:0]          entry_total
);

  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);

  // Entry RAM
  otil_pkg::entry_t mem [ENTRIES];
  otil_pkg::entry_t rd_data;
  logic [AW-1:0]    rd_addr;
  logic             mem_we;
  logic [AW-1:0]    mem_wa;
  otil_pkg::entry_t mem_wd;

  // Control state
  otil_pkg::state_t state, state_next;
  logic [CW-1:0]    count, count_next;
  logic [CW-1:0]    rd_ptr, rd_ptr_next;
  logic             cmp_valid, cmp_valid_next;
  logic [AW-1:0]    cmp_ptr;

  // Latched request
  logic [1:0]                      op_kind;
  logic [otil_pkg::ClassW-1:0]     op_class;
  logic [otil_pkg::CodeW-1:0]      op_code;
  logic [otil_pkg::VersionW-1:0]   op_version;
  logic [otil_pkg::IndexW-1:0]     op_index;

  // Pending result
  logic [2:0]                      res_status, res_status_next;
  logic [otil_pkg::IndexW-1:0]     res_index, res_index_next;
  otil_pkg::entry_t                res_entry, res_entry_next;

  logic accept;
  logic issue;
  logic hit;
  logic out_free;

  assign in_ready = (state == otil_pkg::S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign issue    = (rd_ptr < count);
  assign hit      = cmp_valid && (rd_data.cls == op_class) && (rd_data.code == op_code);

  // RAM read and write ports
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data <= mem[rd_addr];
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      otil_pkg::S_IDLE: begin
        if (accept) begin
          case (kind)
            otil_pkg::KIND_ADD: begin
              if (count >= CW'(ENTRIES)) state_next = otil_pkg::S_REPLY;
              else                       state_next = otil_pkg::S_SCAN;
            end
            otil_pkg::KIND_FIND: state_next = otil_pkg::S_SCAN;
            otil_pkg::KIND_GET: begin
              if ({1'b0, index} < otil_pkg::TotalW'(count)) state_next = otil_pkg::S_GET;
              else                                         state_next = otil_pkg::S_REPLY;
            end
            default: state_next = otil_pkg::S_REPLY;
          endcase
        end
      end
      otil_pkg::S_SCAN: begin
        if (hit || (!issue && !cmp_valid)) state_next = otil_pkg::S_REPLY;
      end
      otil_pkg::S_GET: state_next = otil_pkg::S_REPLY;
      otil_pkg::S_REPLY: begin
        if (out_free) state_next = otil_pkg::S_IDLE;
      end
      default: state_next = otil_pkg::S_IDLE;
    endcase
  end

  // Datapath: RAM addressing, scan pointer, count and result
  always_comb begin
    rd_addr         = rd_ptr[AW-1:0];
    rd_ptr_next     = rd_ptr;
    cmp_valid_next  = 1'b0;
    count_next      = count;
    mem_we          = 1'b0;
    mem_wa          = count[AW-1:0];
    mem_wd          = '{cls: op_class, code: op_code, version: op_version};
    res_status_next = res_status;
    res_index_next  = res_index;
    res_entry_next  = res_entry;
    case (state)
      otil_pkg::S_IDLE: begin
        rd_addr     = index[AW-1:0];
        rd_ptr_next = '0;
        if (accept) begin
          res_status_next = otil_pkg::ST_OK;
          res_index_next  = '0;
          res_entry_next  = '0;
          case (kind)
            otil_pkg::KIND_ADD: begin
              if (count >= CW'(ENTRIES)) res_status_next = otil_pkg::ST_FULL;
            end
            otil_pkg::KIND_GET: begin
              if ({1'b0, index} >= otil_pkg::TotalW'(count)) begin
                res_status_next = otil_pkg::ST_RANGE;
              end
            end
            otil_pkg::KIND_CLEAR: count_next = '0;
            default: ;
          endcase
        end
      end
      otil_pkg::S_SCAN: begin
        if (issue) rd_ptr_next = rd_ptr + CW'(1);
        cmp_valid_next = issue && !hit;
        if (hit) begin
          res_status_next = (op_kind == otil_pkg::KIND_ADD) ? otil_pkg::ST_DUPLICATE
                                                             : otil_pkg::ST_OK;
          res_index_next  = otil_pkg::IndexW'(cmp_ptr);
          res_entry_next  = rd_data;
        end else if (!issue && !cmp_valid) begin
          if (op_kind == otil_pkg::KIND_ADD) begin
            // no duplicate: append at the current count
            mem_we          = 1'b1;
            count_next      = count + CW'(1);
            res_status_next = otil_pkg::ST_OK;
            res_index_next  = otil_pkg::IndexW'(count);
            res_entry_next  = mem_wd;
          end else begin
            res_status_next = otil_pkg::ST_NOT_FOUND;
          end
        end
      end
      otil_pkg::S_GET: begin
        res_index_next = op_index;
        res_entry_next = rd_data;
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= otil_pkg::S_IDLE;
      count     <= '0;
      cmp_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      cmp_valid <= cmp_valid_next;
      if (state == otil_pkg::S_REPLY && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    rd_ptr     <= rd_ptr_next;
    cmp_ptr    <= rd_ptr[AW-1:0];
    res_status <= res_status_next;
    res_index  <= res_index_next;
    res_entry  <= res_entry_next;
    if (accept) begin
      op_kind    <= kind;
      op_class   <= obj_class;
      op_code    <= obis;
      op_version <= version;
      op_index   <= index;
    end
    // output register loads once the previous result has been taken
    if (state == otil_pkg::S_REPLY && out_free) begin
      status        <= res_status;
      entry_index   <= res_index;
      entry_class   <= res_entry.cls;
      entry_code    <= res_entry.code;
      entry_version <= res_entry.version;
      entry_total   <= otil_pkg::TotalW'(count);
    end
  end

endmodule

`default_nettype wire

@@ bench/tb_object_table_insert_lookup_core.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_object_table_insert_lookup_core: self-checking bench for the object table
// Drives add, find, get and clear requests with random gaps and result-side
// stalls, predicts every result from a local copy of the table and compares
// each result field by field, in order.
// ----------------------------------------------------------------------------

module tb_object_table_insert_lookup_core;

  localparam int DEPTH      = 64;
  localparam int TAIL_ITEMS = 150;   // last requests run with no gaps or stalls
  localparam int HANG_LIMIT = 2000;  // cycles with no handshake before giving up
  localparam int MAX_PRINTS = 60;

  typedef struct packed {
    logic [1:0]                    kind;
    logic [otil_pkg::ClassW-1:0]   cls;
    logic [otil_pkg::CodeW-1:0]    code;
    logic [otil_pkg::VersionW-1:0] ver;
    logic [otil_pkg::IndexW-1:0]   idx;
  } req_t;

  typedef struct packed {
    logic [2:0]                    status;
    logic [otil_pkg::IndexW-1:0]   slot;
    logic [otil_pkg::ClassW-1:0]   cls;
    logic [otil_pkg::CodeW-1:0]    code;
    logic [otil_pkg::VersionW-1:0] ver;
    logic [otil_pkg::TotalW-1:0]   total;
  } result_t;

  // Clock, reset and block ports
  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                          in_valid  = 1'b0;
  logic                          out_ready = 1'b0;
  logic [1:0]                    req_kind  = otil_pkg::KIND_GET;
  logic [otil_pkg::ClassW-1:0]   req_class = '0;
  logic [otil_pkg::CodeW-1:0]    req_code  = '0;
  logic [otil_pkg::VersionW-1:0] req_ver   = '0;
  logic [otil_pkg::IndexW-1:0]   req_index = '0;

  logic                          in_ready;
  logic                          out_valid;
  logic [2:0]                    status;
  logic [otil_pkg::IndexW-1:0]   entry_index;
  logic [otil_pkg::ClassW-1:0]   entry_class;
  logic [otil_pkg::CodeW-1:0]    entry_code;
  logic [otil_pkg::VersionW-1:0] entry_version;
  logic [otil_pkg::TotalW-1:0]   entry_total;

  // Stimulus, predicted table and bookkeeping
  req_t    req_queue[$];
  result_t pending_results[$];

  logic [otil_pkg::ClassW-1:0]   tbl_class[DEPTH];
  logic [otil_pkg::CodeW-1:0]    tbl_code[DEPTH];
  logic [otil_pkg::VersionW-1:0] tbl_ver[DEPTH];
  int                            tbl_count = 0;
  int                            peak_fill = 0;

  int n_queued   = 0;
  int n_accepted = 0;
  int n_results  = 0;
  int err_count  = 0;
  int status_seen[5];

  logic req_fire   = 1'b0;
  int   gap_left   = 0;
  int   stall_left = 0;
  bit   gaps_on    = 1'b1;
  bit   stalls_on  = 1'b1;
  int   hang_count = 0;

  // Generator key pool: keys added since the last clear
  logic [otil_pkg::ClassW-1:0] pool_cls[$];
  logic [otil_pkg::CodeW-1:0]  pool_code[$];

  object_table_insert_lookup_core #(
    .ENTRIES(DEPTH)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .kind         (req_kind),
    .obj_class    (req_class),
    .obis         (req_code),
    .version      (req_ver),
    .index        (req_index),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .entry_index  (entry_index),
    .entry_class  (entry_class),
    .entry_code   (entry_code),
    .entry_version(entry_version),
    .entry_total  (entry_total)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Table predictor
  // ---------------------------------------------------------------------------

  // First live slot holding this class and code, or -1
  function automatic int table_search(input logic [otil_pkg::ClassW-1:0] cls,
                                      input logic [otil_pkg::CodeW-1:0] code);
    for (int i = 0; i < tbl_count; i++) begin
      if (tbl_class[i] == cls && tbl_code[i] == code) return i;
    end
    return -1;
  endfunction

  function automatic result_t slot_result(input logic [2:0] st, input int slot);
    result_t r;
    r        = '0;
    r.status = st;
    r.slot   = slot[otil_pkg::IndexW-1:0];
    r.cls    = tbl_class[slot];
    r.code   = tbl_code[slot];
    r.ver    = tbl_ver[slot];
    return r;
  endfunction

  task automatic table_predict(input req_t rq);
    result_t r;
    int      slot;
    r = '0;
    case (rq.kind)
      otil_pkg::KIND_ADD: begin
        if (tbl_count >= DEPTH) begin
          r.status = otil_pkg::ST_FULL;
        end else begin
          slot = table_search(rq.cls, rq.code);
          if (slot >= 0) begin
            r = slot_result(otil_pkg::ST_DUPLICATE, slot);
          end else begin
            slot            = tbl_count;
            tbl_class[slot] = rq.cls;
            tbl_code[slot]  = rq.code;
            tbl_ver[slot]   = rq.ver;
            tbl_count++;
            r = slot_result(otil_pkg::ST_OK, slot);
          end
        end
      end
      otil_pkg::KIND_FIND: begin
        slot = table_search(rq.cls, rq.code);
        if (slot >= 0) r = slot_result(otil_pkg::ST_OK, slot);
        else r.status = otil_pkg::ST_NOT_FOUND;
      end
      otil_pkg::KIND_GET: begin
        if (int'(rq.idx) < tbl_count) r = slot_result(otil_pkg::ST_OK, int'(rq.idx));
        else r.status = otil_pkg::ST_RANGE;
      end
      default: begin
        tbl_count = 0;
      end
    endcase
    if (tbl_count > peak_fill) peak_fill = tbl_count;
    r.total = tbl_count[otil_pkg::TotalW-1:0];
    pending_results.push_back(r);
  endtask

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_error(input string msg);
    err_count++;
    if (err_count <= MAX_PRINTS) $display("[%0t] ERROR %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want)
      report_error($sformatf("result %0d %s: got 0x%0h, want 0x%0h",
                             n_results, name, got, want));
  endtask

  task automatic check_result();
    result_t want;
    if (pending_results.size() == 0) begin
      report_error($sformatf("result with no request pending, status %0d", status));
    end else begin
      want = pending_results.pop_front();
      check_field("status",        64'(status),        64'(want.status));
      check_field("entry_index",   64'(entry_index),   64'(want.slot));
      check_field("entry_class",   64'(entry_class),   64'(want.cls));
      check_field("entry_code",    64'(entry_code),    64'(want.code));
      check_field("entry_version", 64'(entry_version), 64'(want.ver));
      check_field("entry_total",   64'(entry_total),   64'(want.total));
    end
    if (status < 3'd5) status_seen[status]++;
    n_results++;
  endtask

  // Monitor: sample both handshakes at the rising edge
  always @(posedge clk) begin
    if (rst) begin
      req_fire <= 1'b0;
    end else begin
      req_fire <= in_valid && in_ready;
      if (out_valid && out_ready) check_result();
      if (in_valid && in_ready) begin
        table_predict({req_kind, req_class, req_code, req_ver, req_index});
        n_accepted++;
      end
    end
  end

  // Watchdog: no handshake for too long ends the run
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      hang_count = 0;
    end else begin
      hang_count++;
      if (hang_count >= HANG_LIMIT) begin
        $display("[%0t] no handshake for %0d cycles", $time, HANG_LIMIT);
        $display("object_table_insert_lookup_core test failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers (falling edge)
  // ---------------------------------------------------------------------------

  // Request side: hold a request until taken, then next one or a gap
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || req_fire) begin
      if ($urandom_range(0, 149) == 0) gaps_on = !gaps_on;
      if (gap_left == 0 && gaps_on && req_queue.size() > TAIL_ITEMS &&
          $urandom_range(0, 4) == 0)
        gap_left = $urandom_range(1, 13);
      if (gap_left > 0 || req_queue.size() == 0) begin
        if (gap_left > 0) gap_left--;
        in_valid <= 1'b0;
      end else begin
        {req_kind, req_class, req_code, req_ver, req_index} <= req_queue.pop_front();
        in_valid <= 1'b1;
      end
    end
  end

  // Result side: random stall bursts
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if ($urandom_range(0, 149) == 0) stalls_on = !stalls_on;
      if (stall_left == 0 && stalls_on && (n_queued - n_accepted) > TAIL_ITEMS &&
          $urandom_range(0, 5) == 0)
        stall_left = $urandom_range(1, 13);
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  task automatic queue_req(input logic [1:0] kind,
                           input logic [otil_pkg::ClassW-1:0] cls,
                           input logic [otil_pkg::CodeW-1:0] code,
                           input logic [otil_pkg::VersionW-1:0] ver,
                           input logic [otil_pkg::IndexW-1:0] idx);
    req_queue.push_back({kind, cls, code, ver, idx});
    n_queued++;
    if (kind == otil_pkg::KIND_CLEAR) begin
      pool_cls.delete();
      pool_code.delete();
    end else if (kind == otil_pkg::KIND_ADD) begin
      pool_cls.push_back(cls);
      pool_code.push_back(code);
    end
  endtask

  function automatic logic [otil_pkg::CodeW-1:0] rand_code();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[otil_pkg::CodeW-1:0];
  endfunction

  // Key from the pool, a one-bit near miss of a pooled key, or a fresh one
  task automatic pick_key(input int pool_pct, input int near_pct,
                          output logic [otil_pkg::ClassW-1:0] cls,
                          output logic [otil_pkg::CodeW-1:0] code);
    int r;
    int p;
    int b;
    r = $urandom_range(0, 99);
    if (pool_cls.size() != 0 && r < pool_pct + near_pct) begin
      p    = $urandom_range(0, pool_cls.size() - 1);
      cls  = pool_cls[p];
      code = pool_code[p];
      if (r >= pool_pct) begin
        b = $urandom_range(0, otil_pkg::ClassW + otil_pkg::CodeW - 1);
        if (b < otil_pkg::ClassW) cls[b] = ~cls[b];
        else code[b - otil_pkg::ClassW] = ~code[b - otil_pkg::ClassW];
      end
    end else begin
      cls  = ($urandom_range(0, 3) == 0) ? otil_pkg::ClassW'($urandom_range(0, 3))
                                         : otil_pkg::ClassW'($urandom);
      code = rand_code();
    end
  endtask

  initial begin
    logic [otil_pkg::ClassW-1:0] k_cls;
    logic [otil_pkg::CodeW-1:0]  k_code;
    int                          ep_len;
    int                          add_pct;
    int                          r;
    int                          n_rand;

    // Directed: empty table, extreme keys, duplicates, misses, range, clear
    queue_req(otil_pkg::KIND_GET,   16'h0000, 48'h0, 8'h00, 7'd0);
    queue_req(otil_pkg::KIND_GET,   16'hffff, '1,    8'hff, 7'd127);
    queue_req(otil_pkg::KIND_FIND,  16'h0000, 48'h0, 8'h00, 7'd0);
    queue_req(otil_pkg::KIND_ADD,   16'h0000, 48'h0, 8'h00, 7'd0);
    queue_req(otil_pkg::KIND_ADD,   16'hffff, '1,    8'hff, 7'd127);
    queue_req(otil_pkg::KIND_ADD,   16'h0000, '1,    8'h5a, 7'd5);
    queue_req(otil_pkg::KIND_ADD,   16'hffff, 48'h0, 8'ha5, 7'd42);
    queue_req(otil_pkg::KIND_ADD,   16'h0000, 48'h0, 8'h77, 7'd0);  // duplicate of slot 0
    queue_req(otil_pkg::KIND_FIND,  16'hffff, '1,    8'h00, 7'd0);
    queue_req(otil_pkg::KIND_FIND,  16'h0000, 48'h1, 8'h00, 7'd0);  // code off by one bit
    queue_req(otil_pkg::KIND_FIND,  16'h0001, 48'h0, 8'h00, 7'd0);  // class off by one bit
    queue_req(otil_pkg::KIND_FIND,  16'hffff, 48'h0, 8'hff, 7'd127);
    queue_req(otil_pkg::KIND_GET,   16'h0000, 48'h0, 8'h00, 7'd3);
    queue_req(otil_pkg::KIND_GET,   16'h0000, 48'h0, 8'h00, 7'd4);  // first index past count
    queue_req(otil_pkg::KIND_GET,   16'h0000, 48'h0, 8'h00, 7'd127);
    queue_req(otil_pkg::KIND_CLEAR, 16'hffff, '1,    8'hff, 7'd127);
    queue_req(otil_pkg::KIND_FIND,  16'h0000, 48'h0, 8'h00, 7'd0);
    queue_req(otil_pkg::KIND_GET,   16'h0000, 48'h0, 8'h00, 7'd0);
    queue_req(otil_pkg::KIND_ADD,   16'h1234, 48'h0102_0304_0506, 8'h01, 7'd0);
    queue_req(otil_pkg::KIND_GET,   16'h0000, 48'h0, 8'h00, 7'd0);
    queue_req(otil_pkg::KIND_ADD,   16'h1234, 48'h0102_0304_0506, 8'h02, 7'd0);
    queue_req(otil_pkg::KIND_CLEAR, 16'h0000, 48'h0, 8'h00, 7'd0);

    // Random: first fill the table past full, then episodes opened by a clear
    for (int i = 0; i < 70; i++)
      queue_req(otil_pkg::KIND_ADD, otil_pkg::ClassW'($urandom), rand_code(),
                otil_pkg::VersionW'($urandom), otil_pkg::IndexW'($urandom));
    n_rand = 70;
    while (n_rand < 1000) begin
      ep_len  = $urandom_range(10, 200);
      add_pct = $urandom_range(30, 90);
      queue_req(otil_pkg::KIND_CLEAR, otil_pkg::ClassW'($urandom), rand_code(),
                otil_pkg::VersionW'($urandom), otil_pkg::IndexW'($urandom));
      n_rand++;
      for (int i = 0; i < ep_len && n_rand < 1000; i++) begin
        r = $urandom_range(0, 99);
        if (r < 2) begin
          queue_req(otil_pkg::KIND_CLEAR, otil_pkg::ClassW'($urandom), rand_code(),
                    otil_pkg::VersionW'($urandom), otil_pkg::IndexW'($urandom));
        end else if (r < 2 + add_pct) begin
          pick_key(20, 10, k_cls, k_code);
          queue_req(otil_pkg::KIND_ADD, k_cls, k_code, otil_pkg::VersionW'($urandom),
                    otil_pkg::IndexW'($urandom));
        end else if (r[0]) begin
          pick_key(60, 20, k_cls, k_code);
          queue_req(otil_pkg::KIND_FIND, k_cls, k_code, otil_pkg::VersionW'($urandom),
                    otil_pkg::IndexW'($urandom));
        end else begin
          queue_req(otil_pkg::KIND_GET, otil_pkg::ClassW'($urandom), rand_code(),
                    otil_pkg::VersionW'($urandom),
                    ($urandom_range(0, 4) == 0) ? otil_pkg::IndexW'($urandom_range(0, 127))
                                                : otil_pkg::IndexW'($urandom_range(0, 70)));
        end
        n_rand++;
      end
    end

    // Reset, then let the drivers run until every result is in
    repeat (6) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    while (n_accepted < n_queued || pending_results.size() != 0) @(posedge clk);
    repeat (DEPTH + 16) @(posedge clk);

    $display("Ran %0d requests: %0d ok, %0d full, %0d duplicate, %0d not found,",
             n_results, status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
    $display("%0d out of range; table filled to %0d of %0d entries; %0d errors.",
             status_seen[4], peak_fill, DEPTH, err_count);
    if (err_count == 0 && pending_results.size() == 0) begin
      $display("object_table_insert_lookup_core test passed");
    end else begin
      $display("object_table_insert_lookup_core test failed");
    end
    $finish;
  end

endmodule
